>>> src/freq_residency_transition_stats_assert.svh
// Assertion macros shared by the frequency statistics RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef FREQ_RESIDENCY_TRANSITION_STATS_ASSERT_SVH
`define FREQ_RESIDENCY_TRANSITION_STATS_ASSERT_SVH

// property holds at every clock edge out of reset
`define FRTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("frts assertion failed");

// consequent holds in the cycle after the antecedent
`define FRTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frts assertion failed");

`endif

>>> src/frts_pkg.sv
// Types and constants for the frequency residency and transition statistics block.
// No dependencies.
`default_nettype none

package frts_pkg;

  localparam int MaxStates  = 16;
  localparam int IdxW       = $clog2(MaxStates);
  localparam int CntW       = $clog2(MaxStates + 1);
  localparam int TransDepth = MaxStates * MaxStates;
  localparam int TransAw    = $clog2(TransDepth);

  localparam logic [2:0] KindAdd       = 3'd0;
  localparam logic [2:0] KindStart     = 3'd1;
  localparam logic [2:0] KindChange    = 3'd2;
  localparam logic [2:0] KindReadRes   = 3'd3;
  localparam logic [2:0] KindReadTrans = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StIgnored = 2'd1;
  localparam logic [1:0] StDupFull = 2'd2;
  localparam logic [1:0] StRange   = 2'd3;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] freq_khz;
    logic [63:0] now_ticks;
    logic [3:0]  from_index;
    logic [3:0]  to_index;
  } item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  assigned_index;
    logic [31:0] total_transitions;
    logic [1:0]  status;
  } result_t;

  function automatic logic [TransAw-1:0] trans_addr(input logic [IdxW-1:0] src,
                                                    input logic [IdxW-1:0] dst);
    trans_addr = TransAw'(TransAw'(src) * TransAw'(MaxStates) + TransAw'(dst));
  endfunction

endpackage

`default_nettype wire

>>> src/frts_alu.sv
// Shared 64-bit add/subtract and equality unit.
// Depends on frts_pkg.
`default_nettype none

module frts_alu (
  input  wire logic             [63:0] a_i,
  input  wire logic             [63:0] b_i,
  input  wire frts_pkg::alu_op_e       op_i,
  output logic                  [63:0] sum_o,
  output logic                         eq_o
);

  logic        sub;
  logic [63:0] b_eff;

  assign sub   = (op_i == frts_pkg::ALU_SUB);
  assign b_eff = sub ? ~b_i : b_i;
  assign sum_o = a_i + b_eff + 64'(sub);
  assign eq_o  = (a_i == b_i);

endmodule

`default_nettype wire

>>> src/frts_trans_mem.sv
// Transition count memory with per-entry valid bits; unwritten entries read as zero.
// Depends on frts_pkg and the assertion macro header.
`default_nettype none
`include "freq_residency_transition_stats_assert.svh"

module frts_trans_mem (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_en_i,
  input  wire logic [frts_pkg::TransAw-1:0] wr_addr_i,
  input  wire logic [31:0]                  wr_data_i,
  input  wire logic                         rd_en_i,
  input  wire logic [frts_pkg::TransAw-1:0] rd_addr_i,
  output logic      [31:0]                  rd_data_o
);

  logic [31:0]                     mem [frts_pkg::TransDepth];
  logic [frts_pkg::TransDepth-1:0] vld_q;
  logic [31:0]                     rdata_q;
  logic                            rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rdata_q : '0;

  `FRTS_ASSERT(a_no_rw_clash, !(wr_en_i && rd_en_i))
  `FRTS_ASSERT_NEXT(a_wr_sets_vld, wr_en_i, vld_q[$past(wr_addr_i)])
  `FRTS_ASSERT_NEXT(a_rd_vld, rd_en_i && vld_q[rd_addr_i], rd_vld_q)

endmodule

`default_nettype wire

>>> src/freq_residency_transition_stats.sv
// Top level: sequencer, frequency table, residency counters and total count.
// Depends on frts_pkg, frts_alu, frts_trans_mem and the assertion macro header.
//
// Use: present a word on item_i and raise start; it is taken at a clock edge
// where start is high and busy is low. busy then stays high while the
// sequencer works on the word, unless it is ignored at accept. Exactly
// one result word appears on result_o for one cycle, marked by done_o; it
// must be captured then, there is no back-pressure. busy falls in the
// cycle done_o is shown, so the next word may be started at once.
// Work per kind, in sequencer state order:
//   add / start      : table search up to the match or the table end
//   change           : ignored with no current state; else search, and if
//                      counted subtract, accumulate, count increments
//   residency read   : subtract and accumulate first with a current state
//   transition read  : read, or range status; unused kinds ignored
// The table search compares one entry per cycle through the shared 64-bit
// ALU, which also does the elapsed-time subtract, residency accumulate and
// counter increments one after another.
// Reset (asynchronous, active low) clears the table count, residency and
// transition counters, the total and the current state; no clearing pass.
`default_nettype none
`include "freq_residency_transition_stats_assert.svh"

module freq_residency_transition_stats (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire frts_pkg::item_t   item_i,
  output logic                   busy,
  output logic                   done_o,
  output frts_pkg::result_t      result_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DIFF,
    S_ACCUM,
    S_TRD,
    S_TINC,
    S_TOTAL,
    S_RDRES,
    S_TROUT
  } state_e;

  state_e                      state_q;
  frts_pkg::item_t             item_q;
  logic [frts_pkg::CntW-1:0]   ptr_q;
  logic [frts_pkg::CntW-1:0]   cnt_q;
  logic [frts_pkg::IdxW-1:0]   fidx_q;
  logic [frts_pkg::IdxW-1:0]   cur_q;
  logic                        cur_vld_q;
  logic [63:0]                 diff_q;
  logic [63:0]                 prev_q;
  logic [31:0]                 total_q;
  logic [63:0]                 res_q [frts_pkg::MaxStates];
  logic [23:0]                 freq_list_q [frts_pkg::MaxStates];
  frts_pkg::result_t           out_q;
  logic                        done_q;

  logic [63:0]                 alu_a;
  logic [63:0]                 alu_b;
  frts_pkg::alu_op_e           alu_op;
  logic [63:0]                 alu_sum;
  logic                        alu_eq;

  logic [frts_pkg::IdxW-1:0]   ptr_idx;
  logic                        srch_end;
  logic                        srch_hit;
  logic                        fl_we;
  logic [frts_pkg::IdxW-1:0]   res_raddr;
  logic [63:0]                 res_rdata;
  logic                        from_bad;
  logic                        to_bad;
  logic                        t_wr_en;
  logic                        t_rd_en;
  logic [frts_pkg::TransAw-1:0] t_addr;
  logic [31:0]                 t_rdata;
  logic [frts_pkg::CntW-1:0]   cur_ext;

  assign ptr_idx   = ptr_q[frts_pkg::IdxW-1:0];
  assign srch_end  = (ptr_q == cnt_q);
  assign srch_hit  = !srch_end && alu_eq;
  assign res_raddr = (state_q == S_RDRES) ? item_q.from_index : cur_q;
  assign res_rdata = res_q[res_raddr];
  assign from_bad  = (frts_pkg::CntW'(item_q.from_index) >= cnt_q);
  assign to_bad    = (frts_pkg::CntW'(item_q.to_index) >= cnt_q);
  assign cur_ext   = frts_pkg::CntW'(cur_q);

  assign fl_we = (state_q == S_SEARCH) && srch_end &&
                 (item_q.kind == frts_pkg::KindAdd) &&
                 (cnt_q < frts_pkg::CntW'(frts_pkg::MaxStates));

  assign t_rd_en = (state_q == S_TRD);
  assign t_wr_en = (state_q == S_TINC);
  assign t_addr  = (item_q.kind == frts_pkg::KindReadTrans) ?
                   frts_pkg::trans_addr(item_q.from_index, item_q.to_index) :
                   frts_pkg::trans_addr(cur_q, fidx_q);

  always_comb begin
    alu_op = frts_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_q)
      S_SEARCH: begin
        alu_a = 64'(freq_list_q[ptr_idx]);
        alu_b = 64'(item_q.freq_khz);
      end
      S_DIFF: begin
        alu_op = frts_pkg::ALU_SUB;
        alu_a  = item_q.now_ticks;
        alu_b  = prev_q;
      end
      S_ACCUM: begin
        alu_a = res_rdata;
        alu_b = diff_q;
      end
      S_TINC: begin
        alu_a = 64'(t_rdata);
        alu_b = 64'd1;
      end
      S_TOTAL: begin
        alu_a = 64'(total_q);
        alu_b = 64'd1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  frts_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .sum_o (alu_sum),
    .eq_o  (alu_eq)
  );

  frts_trans_mem u_trans_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (t_wr_en),
    .wr_addr_i (t_addr),
    .wr_data_i (alu_sum[31:0]),
    .rd_en_i   (t_rd_en),
    .rd_addr_i (t_addr),
    .rd_data_o (t_rdata)
  );

  // table entries hold no reset: only the first cnt_q are ever searched
  always_ff @(posedge clk_i) begin
    if (fl_we) begin
      freq_list_q[cnt_q[frts_pkg::IdxW-1:0]] <= item_q.freq_khz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      item_q    <= '0;
      ptr_q     <= '0;
      cnt_q     <= '0;
      fidx_q    <= '0;
      cur_q     <= '0;
      cur_vld_q <= 1'b0;
      diff_q    <= '0;
      prev_q    <= '0;
      total_q   <= '0;
      out_q     <= '0;
      done_q    <= 1'b0;
      for (int i = 0; i < frts_pkg::MaxStates; i++) begin
        res_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            item_q <= item_i;
            ptr_q  <= '0;
            out_q  <= '0;
            out_q.total_transitions <= total_q;
            unique case (item_i.kind)
              frts_pkg::KindAdd: begin
                state_q <= S_SEARCH;
              end
              frts_pkg::KindStart: begin
                prev_q  <= item_i.now_ticks;
                state_q <= S_SEARCH;
              end
              frts_pkg::KindChange: begin
                if (cur_vld_q) begin
                  state_q <= S_SEARCH;
                end else begin
                  out_q.status <= frts_pkg::StIgnored;
                  done_q       <= 1'b1;
                end
              end
              frts_pkg::KindReadRes: begin
                state_q <= cur_vld_q ? S_DIFF : S_RDRES;
              end
              frts_pkg::KindReadTrans: begin
                state_q <= S_TRD;
              end
              default: begin
                out_q.status <= frts_pkg::StIgnored;
                done_q       <= 1'b1;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (srch_hit || srch_end) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            unique case (item_q.kind)
              frts_pkg::KindAdd: begin
                if (srch_hit) begin
                  out_q.status         <= frts_pkg::StDupFull;
                  out_q.assigned_index <= ptr_idx;
                end else if (fl_we) begin
                  out_q.assigned_index <= cnt_q[frts_pkg::IdxW-1:0];
                  cnt_q                <= cnt_q + 1'b1;
                end else begin
                  out_q.status <= frts_pkg::StDupFull;
                end
              end
              frts_pkg::KindStart: begin
                cur_vld_q <= srch_hit;
                if (srch_hit) begin
                  cur_q                <= ptr_idx;
                  out_q.assigned_index <= ptr_idx;
                end else begin
                  out_q.status <= frts_pkg::StIgnored;
                end
              end
              default: begin
                if (srch_hit && (ptr_idx != cur_q)) begin
                  fidx_q  <= ptr_idx;
                  state_q <= S_DIFF;
                  done_q  <= 1'b0;
                end else begin
                  out_q.status <= frts_pkg::StIgnored;
                end
              end
            endcase
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        S_DIFF: begin
          diff_q  <= alu_sum;
          state_q <= S_ACCUM;
        end
        S_ACCUM: begin
          res_q[cur_q] <= alu_sum;
          prev_q       <= item_q.now_ticks;
          state_q      <= (item_q.kind == frts_pkg::KindChange) ? S_TRD : S_RDRES;
        end
        S_TRD: begin
          if (item_q.kind == frts_pkg::KindChange) begin
            state_q <= S_TINC;
          end else if (from_bad || to_bad) begin
            out_q.status <= frts_pkg::StRange;
            state_q      <= S_IDLE;
            done_q       <= 1'b1;
          end else begin
            state_q <= S_TROUT;
          end
        end
        S_TINC: begin
          state_q <= S_TOTAL;
        end
        S_TOTAL: begin
          total_q                 <= alu_sum[31:0];
          out_q.total_transitions <= alu_sum[31:0];
          cur_q                   <= fidx_q;
          state_q                 <= S_IDLE;
          done_q                  <= 1'b1;
        end
        S_RDRES: begin
          if (from_bad) begin
            out_q.status <= frts_pkg::StRange;
          end else begin
            out_q.value <= res_rdata;
          end
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        S_TROUT: begin
          out_q.value <= 64'(t_rdata);
          state_q     <= S_IDLE;
          done_q      <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = out_q;

  `FRTS_ASSERT(a_done_idle, done_o |-> !busy)
  `FRTS_ASSERT_NEXT(a_accept_busy_or_done, start && !busy, busy || done_o)
  `FRTS_ASSERT(a_cnt_range, cnt_q <= frts_pkg::CntW'(frts_pkg::MaxStates))
  `FRTS_ASSERT(a_cur_known, cur_vld_q |-> (cur_ext < cnt_q))

endmodule

`default_nettype wire
